// ===== rtl/bafd_pkg.sv =====
// Shared types and constants for the ADC frame deframer.
`timescale 1ns / 1ps
package bafd_pkg;

  // Number of converter channels carried in one frame
  localparam int unsigned CHANNELS = 8;

  localparam logic [7:0] HEADER_BYTE = 8'hC0;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_STATUS = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  // One emitted sample beat
  typedef struct packed {
    logic [2:0]         channel_index;
    logic signed [23:0] sample;
    logic               last_channel;
  } result_t;

endpackage

// ===== rtl/biopotential_adc_frame_deframer.sv =====
// Top level of the multichannel ADC serial frame deframer.
`timescale 1ns / 1ps
// Takes one received byte per beat, finds a 0xC0 header, skips two status
// bytes and turns the following 24 data bytes into eight big-endian 24-bit
// samples; samples of channels below channel_count (clamped to eight) leave as
// beats carrying the channel number and a last-channel flag. One byte is taken
// every cycle while in_stall is low; a result passes through the parser's
// result register and then a two-entry buffer before it is presented.
// in_stall rises only while that buffer holds two beats. channel_count resets
// to 8 and is written through the cfg port, which is always ready.
module biopotential_adc_frame_deframer import bafd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         channel_index,
  output logic signed [23:0] sample,
  output logic               last_channel
);

  logic [3:0] channel_count;
  logic [3:0] eff_count;
  logic       take;
  logic       push;
  logic       full;
  result_t    result;
  result_t    head;

  assign cfg_ready = 1'b1;

  // Hold the channel count register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      channel_count <= cfg_data;
    end
  end

  // Clamp to the channels in a frame
  assign eff_count = (channel_count > 4'(CHANNELS)) ? 4'(CHANNELS) : channel_count;

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  bafd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .eff_count (eff_count),
    .push      (push),
    .result    (result)
  );

  bafd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (out_valid && !out_stall),
    .full      (full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign channel_index = head.channel_index;
  assign sample        = head.sample;
  assign last_channel  = head.last_channel;

endmodule

// ===== rtl/bafd_parser.sv =====
// Frame parser: hunts for the header, skips status, assembles 24-bit samples.
`timescale 1ns / 1ps
module bafd_parser import bafd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  input  logic [3:0]  eff_count,
  output logic        push,
  output result_t     result
);

  phase_t      phase;
  phase_t      phase_next;
  logic        status_pos;
  logic [1:0]  byte_in_ch;
  logic [2:0]  chan;
  logic [15:0] partial_sample;
  logic        emit;

  // Emit on the third byte of a channel below the active count
  assign emit = take && (phase == PH_DATA) && (byte_in_ch == 2'd2) &&
                ({1'b0, chan} < eff_count);

  // Pick the next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == HEADER_BYTE) phase_next = PH_STATUS;
      end
      PH_STATUS: begin
        if (status_pos) phase_next = PH_DATA;
      end
      PH_DATA: begin
        if ((byte_in_ch == 2'd2) && (chan == 3'd7)) phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == HEADER_BYTE) ? PH_STATUS : PH_HUNT;
      end
    endcase
  end

  // Advance byte counters and phase on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      status_pos <= 1'b0;
      byte_in_ch <= 2'd0;
      chan       <= 3'd0;
    end else if (take) begin
      phase <= phase_next;
      if (phase == PH_STATUS) begin
        status_pos <= ~status_pos;
      end else begin
        status_pos <= 1'b0;
      end
      if (phase == PH_DATA) begin
        if (byte_in_ch == 2'd2) begin
          byte_in_ch <= 2'd0;
          chan       <= chan + 3'd1;
        end else begin
          byte_in_ch <= byte_in_ch + 2'd1;
        end
      end else begin
        byte_in_ch <= 2'd0;
        chan       <= 3'd0;
      end
    end
  end

  // Collect the upper two bytes of the sample
  always_ff @(posedge clk) begin
    if (take && (phase == PH_DATA) && (byte_in_ch != 2'd2)) begin
      partial_sample <= {partial_sample[7:0], rx_byte};
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.channel_index <= chan;
      result.sample        <= $signed({partial_sample, rx_byte});
      result.last_channel  <= (({1'b0, chan} + 4'd1) == eff_count);
    end
  end

  // A frame ends after the eighth channel's last byte
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (take && (phase == PH_DATA) && (byte_in_ch == 2'd2) && (chan == 3'd7)) |=>
    (phase == PH_HUNT))
    else $error("frame did not end after the last data byte");

  // Status skip lasts two bytes
  a_status_len: assert property (@(posedge clk) disable iff (rst)
    (take && (phase == PH_STATUS) && !status_pos) |=> (phase == PH_STATUS))
    else $error("status skip ended early");

  // A flagged last channel matches the active count
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    push |-> (result.last_channel == (({1'b0, result.channel_index} + 4'd1) == $past(eff_count))))
    else $error("last channel flag inconsistent with channel count");

endmodule

// ===== rtl/bafd_out_buf.sv =====
// Two-entry result buffer so the input keeps flowing while a beat waits.
`timescale 1ns / 1ps
module bafd_out_buf import bafd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output result_t head
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Write the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Never write into a full buffer unless a beat is popped at the same time
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("result buffer overflow");

  // A pushed beat is visible next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> not_empty)
    else $error("pushed beat not presented");

  // Fill level stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

endmodule
